@@ design/b58_pkg.sv @@
// Shared types, constants and the character table of the Base58 encoder.
package b58_pkg;

  // Sizes of the encoder.
  localparam int MAX_BYTES      = 25;
  localparam int DIGIT_CAPACITY = 40;
  localparam int MAX_RESULTS    = 35;
  localparam int RADIX          = 58;

  // Widths of the internal counters, digits and arithmetic values.
  localparam int CNT_W   = 6;
  localparam int DIGIT_W = 6;
  localparam int CARRY_W = 9;
  localparam int VAL_W   = 14;
  localparam int CHAR_W  = 7;

  // floor(v / 58) = (v * RECIP_58) >> DIV_SHIFT, exact for every 14-bit v.
  localparam int RECIP_W   = 15;
  localparam int RECIP_58  = 18079;
  localparam int DIV_SHIFT = 20;
  localparam int PROD_W    = VAL_W + RECIP_W;

  localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_GROW,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
    logic              too_long;
  } b58_result_t;

  // Maps a base-58 digit to its character; codes above 57 read as the zero digit.
  function automatic logic [CHAR_W-1:0] alphabet(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    unique case (d)
      6'd0:  c = 7'h31;  6'd1:  c = 7'h32;  6'd2:  c = 7'h33;  6'd3:  c = 7'h34;
      6'd4:  c = 7'h35;  6'd5:  c = 7'h36;  6'd6:  c = 7'h37;  6'd7:  c = 7'h38;
      6'd8:  c = 7'h39;  6'd9:  c = 7'h41;  6'd10: c = 7'h42;  6'd11: c = 7'h43;
      6'd12: c = 7'h44;  6'd13: c = 7'h45;  6'd14: c = 7'h46;  6'd15: c = 7'h47;
      6'd16: c = 7'h48;  6'd17: c = 7'h4A;  6'd18: c = 7'h4B;  6'd19: c = 7'h4C;
      6'd20: c = 7'h4D;  6'd21: c = 7'h4E;  6'd22: c = 7'h50;  6'd23: c = 7'h51;
      6'd24: c = 7'h52;  6'd25: c = 7'h53;  6'd26: c = 7'h54;  6'd27: c = 7'h55;
      6'd28: c = 7'h56;  6'd29: c = 7'h57;  6'd30: c = 7'h58;  6'd31: c = 7'h59;
      6'd32: c = 7'h5A;  6'd33: c = 7'h61;  6'd34: c = 7'h62;  6'd35: c = 7'h63;
      6'd36: c = 7'h64;  6'd37: c = 7'h65;  6'd38: c = 7'h66;  6'd39: c = 7'h67;
      6'd40: c = 7'h68;  6'd41: c = 7'h69;  6'd42: c = 7'h6A;  6'd43: c = 7'h6B;
      6'd44: c = 7'h6D;  6'd45: c = 7'h6E;  6'd46: c = 7'h6F;  6'd47: c = 7'h70;
      6'd48: c = 7'h71;  6'd49: c = 7'h72;  6'd50: c = 7'h73;  6'd51: c = 7'h74;
      6'd52: c = 7'h75;  6'd53: c = 7'h76;  6'd54: c = 7'h77;  6'd55: c = 7'h78;
      6'd56: c = 7'h79;  6'd57: c = 7'h7A;
      default: c = CHAR_ONE;
    endcase
    return c;
  endfunction

endpackage

@@ design/b58_divmod.sv @@
// Shared divide-by-58 unit: quotient by reciprocal multiplication, remainder by shifts and subtraction.
module b58_divmod (
  input  logic [b58_pkg::VAL_W-1:0]   val,
  output logic [b58_pkg::CARRY_W-1:0] quot,
  output logic [b58_pkg::DIGIT_W-1:0] rem
);

  logic [b58_pkg::PROD_W-1:0] prod;
  logic [b58_pkg::VAL_W:0]    qx;
  logic [b58_pkg::VAL_W:0]    q58;
  logic [b58_pkg::VAL_W:0]    diff;

  assign prod = b58_pkg::PROD_W'(val) * b58_pkg::PROD_W'(b58_pkg::RECIP_58);
  assign quot = prod[b58_pkg::DIV_SHIFT +: b58_pkg::CARRY_W];

  // 58 * q = 64q - 4q - 2q; the difference always lies below 58.
  assign qx   = (b58_pkg::VAL_W + 1)'(quot);
  assign q58  = (qx << 6) - (qx << 2) - (qx << 1);
  assign diff = (b58_pkg::VAL_W + 1)'(val) - q58;
  assign rem  = diff[b58_pkg::DIGIT_W-1:0];

endmodule

@@ design/b58_out_reg.sv @@
// Output register that holds one result character until the consumer takes it.
module b58_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  b58_pkg::b58_result_t res_in,
  input  logic                 out_stall,
  output logic                 can_take,
  output logic                 out_valid,
  output b58_pkg::b58_result_t res_out
);

  assign can_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && push) begin
      res_out <= res_in;
    end
  end

endmodule

@@ design/base58_radix_encoder_top.sv @@
// Base58 encoder (Bitcoin alphabet) fed one byte per transaction, most
// significant byte first, with last_byte on the final byte. One shared
// divide-by-58 unit updates the stored digits one per cycle and then grows
// the number by up to two digits. A byte that is folded in therefore keeps
// in_stall high until its digits are updated and the number has grown, so
// the next byte waits for that. A byte beyond the 25-byte limit is not
// folded in and sets too_long. After the final byte the text leaves one
// character at a time, one leading '1' per leading zero byte and then the
// digits, each through a read state and then an emit state, as the digit
// memory has a single read port. in_stall is high from the acceptance of a
// folded or final byte until the block has finished with it.
module base58_radix_encoder_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b58_pkg::CHAR_W-1:0]  out_char,
  output logic                        last_char,
  output logic                        too_long
);

  localparam int CW = b58_pkg::CNT_W;

  b58_pkg::state_t state, state_next;

  logic [CW-1:0]                   digit_count, digit_count_next;
  logic [CW-1:0]                   zero_prefix, zero_prefix_next;
  logic                            nonzero_seen, nonzero_seen_next;
  logic [CW-1:0]                   bytes_taken, bytes_taken_next;
  logic                            overflow, overflow_next;
  logic                            last_seen, last_seen_next;
  logic [b58_pkg::CARRY_W-1:0]     carry, carry_next;
  logic [CW-1:0]                   idx, idx_next;

  logic [b58_pkg::DIGIT_W-1:0]     mem [b58_pkg::DIGIT_CAPACITY];
  logic [b58_pkg::DIGIT_W-1:0]     rdata;
  logic [CW-1:0]                   rd_addr;
  logic [CW-1:0]                   wr_addr;
  logic [b58_pkg::DIGIT_W-1:0]     wr_data;
  logic                            wr_en;

  logic [b58_pkg::VAL_W-1:0]       dm_val;
  logic [b58_pkg::CARRY_W-1:0]     dm_quot;
  logic [b58_pkg::DIGIT_W-1:0]     dm_rem;

  logic [CW:0]                     sum_total;
  logic [CW-1:0]                   total;
  logic [CW-1:0]                   idx_inc;
  logic                            in_accept;

  b58_pkg::b58_result_t            res_in, res_out;
  logic                            push, can_take;

  b58_divmod u_divmod (
    .val  (dm_val),
    .quot (dm_quot),
    .rem  (dm_rem)
  );

  b58_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_in    (res_in),
    .out_stall (out_stall),
    .can_take  (can_take),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_char  = res_out.out_char;
  assign last_char = res_out.last_char;
  assign too_long  = res_out.too_long;

  assign in_stall  = (state != b58_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign sum_total = (CW + 1)'(zero_prefix) + (CW + 1)'(digit_count);
  assign total     = (sum_total > (CW + 1)'(b58_pkg::MAX_RESULTS)) ?
                     CW'(b58_pkg::MAX_RESULTS) : sum_total[CW-1:0];
  assign idx_inc   = idx + CW'(1);

  // Digit memory, least significant digit at address zero.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= b58_pkg::S_IDLE;
      digit_count  <= '0;
      zero_prefix  <= '0;
      nonzero_seen <= 1'b0;
      bytes_taken  <= '0;
      overflow     <= 1'b0;
      last_seen    <= 1'b0;
      carry        <= '0;
      idx          <= '0;
    end else begin
      state        <= state_next;
      digit_count  <= digit_count_next;
      zero_prefix  <= zero_prefix_next;
      nonzero_seen <= nonzero_seen_next;
      bytes_taken  <= bytes_taken_next;
      overflow     <= overflow_next;
      last_seen    <= last_seen_next;
      carry        <= carry_next;
      idx          <= idx_next;
    end
  end

  always_comb begin
    state_next        = state;
    digit_count_next  = digit_count;
    zero_prefix_next  = zero_prefix;
    nonzero_seen_next = nonzero_seen;
    bytes_taken_next  = bytes_taken;
    overflow_next     = overflow;
    last_seen_next    = last_seen;
    carry_next        = carry;
    idx_next          = idx;
    rd_addr           = '0;
    wr_en             = 1'b0;
    wr_addr           = idx;
    wr_data           = dm_rem;
    dm_val            = b58_pkg::VAL_W'(carry);
    push              = 1'b0;
    res_in.out_char   = b58_pkg::CHAR_ONE;
    res_in.last_char  = (idx_inc == total);
    res_in.too_long   = overflow;

    unique case (state)
      b58_pkg::S_IDLE: begin
        if (in_accept) begin
          idx_next       = '0;
          last_seen_next = last_byte;
          if (bytes_taken < CW'(b58_pkg::MAX_BYTES)) begin
            carry_next       = b58_pkg::CARRY_W'(data_byte);
            bytes_taken_next = bytes_taken + CW'(1);
            if (!nonzero_seen) begin
              if (data_byte == 8'd0) begin
                zero_prefix_next = zero_prefix + CW'(1);
              end else begin
                nonzero_seen_next = 1'b1;
              end
            end
            state_next = (digit_count != '0) ? b58_pkg::S_FOLD : b58_pkg::S_GROW;
          end else begin
            overflow_next = 1'b1;
            if (last_byte) begin
              state_next = b58_pkg::S_EMIT_RD;
            end
          end
        end
      end

      b58_pkg::S_FOLD: begin
        // The read of this digit was issued in the previous cycle.
        dm_val     = {rdata, 8'h00} + b58_pkg::VAL_W'(carry);
        wr_en      = 1'b1;
        wr_addr    = idx;
        carry_next = dm_quot;
        idx_next   = idx_inc;
        rd_addr    = (idx_inc < CW'(b58_pkg::DIGIT_CAPACITY)) ? idx_inc : '0;
        if (idx_inc == digit_count) begin
          state_next = b58_pkg::S_GROW;
        end
      end

      b58_pkg::S_GROW: begin
        if (carry == '0 || digit_count == CW'(b58_pkg::DIGIT_CAPACITY)) begin
          idx_next   = '0;
          state_next = last_seen ? b58_pkg::S_EMIT_RD : b58_pkg::S_IDLE;
        end else begin
          wr_en            = 1'b1;
          wr_addr          = digit_count;
          carry_next       = dm_quot;
          digit_count_next = digit_count + CW'(1);
        end
      end

      b58_pkg::S_EMIT_RD: begin
        // Digits leave most significant first, after the leading ones.
        if (idx >= zero_prefix) begin
          rd_addr = digit_count - CW'(1) - idx + zero_prefix;
        end
        state_next = b58_pkg::S_EMIT;
      end

      b58_pkg::S_EMIT: begin
        // The read address is held so that the digit survives a stalled output.
        if (idx >= zero_prefix) begin
          rd_addr         = digit_count - CW'(1) - idx + zero_prefix;
          res_in.out_char = b58_pkg::alphabet(rdata);
        end
        if (can_take) begin
          push = 1'b1;
          if (res_in.last_char) begin
            digit_count_next  = '0;
            zero_prefix_next  = '0;
            nonzero_seen_next = 1'b0;
            bytes_taken_next  = '0;
            overflow_next     = 1'b0;
            last_seen_next    = 1'b0;
            carry_next        = '0;
            idx_next          = '0;
            state_next        = b58_pkg::S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = b58_pkg::S_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = b58_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ design/b58_checker.sv @@
// Port-level checker for the Base58 encoder, bound to the top level.
module b58_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       last_byte,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [b58_pkg::CHAR_W-1:0] out_char,
  input logic                       last_char,
  input logic                       too_long
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) &&
      $stable(last_char) && $stable(too_long))
    else $error("stalled result changed");

  // Every character lies within the alphabet's code range.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= 7'h31 && out_char <= 7'h7A))
    else $error("character outside the alphabet range");

  // A final byte always leaves the block busy in the following cycle.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> in_stall)
    else $error("block ready straight after a final byte");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind base58_radix_encoder_top b58_checker u_b58_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .last_char (last_char),
  .too_long  (too_long)
);
